// ----- hw/rtl/gsc_mbe_pkg.sv -----
// Shared types, constants and coding functions of the pager message block encoder.
`default_nettype none

package gsc_mbe_pkg;

   localparam int BLOCK_CODES = 8;
   localparam int CODE_W      = 6;
   localparam int COUNT_W     = $clog2(BLOCK_CODES);
   localparam int WORD_W      = 7;
   localparam int CW_W        = 15;
   localparam int RES_IDX_W   = 4;

   localparam logic [CODE_W-1:0]    ALPHA_FILL   = 6'h3e;
   localparam logic [CODE_W-1:0]    NUMERIC_FILL = 6'h0a;
   localparam logic [8:0]           BCH_GEN      = 9'h1d1;
   localparam logic [COUNT_W-1:0]   LAST_SLOT    = 3'd7;
   localparam logic [RES_IDX_W-1:0] COMMA_IDX    = 4'd0;
   localparam logic [RES_IDX_W-1:0] LAST_IDX     = 4'd15;
   localparam logic [3:0]           COMMA_BITS   = 4'd1;
   localparam logic [3:0]           COLUMN_BITS  = 4'd8;

   // Configuration register indexes.
   localparam int              CSR_IDX_W        = 1;
   localparam int              CSR_ADDR_W       = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_MESSAGE_TYPE = 1'b0;

   // Message type codes.
   localparam logic MSG_ALPHA   = 1'b0;
   localparam logic MSG_NUMERIC = 1'b1;

   typedef struct packed {
      logic [7:0] character;
      logic       last_char;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] symbol_bits;
      logic [3:0] bit_count;
      logic       end_of_block;
      logic       bad_char;
   } rsp_payload_type;

   typedef struct packed {
      logic              ok;
      logic [CODE_W-1:0] code;
   } num_code_type;

   // One finished block: the eight codewords, or a bad character marker.
   typedef struct packed {
      logic                            bad;
      logic [BLOCK_CODES-1:0][CW_W-1:0] cw;
   } blk_type;

   function automatic logic [CODE_W-1:0] map_alpha(input logic [7:0] c);
      logic [7:0]        u;
      logic [7:0]        d;
      logic [CODE_W-1:0] r;
      u = c;
      if (c >= 8'h61 && c <= 8'h7a) begin
         u = c - 8'h20;
      end
      d = u - 8'h20;
      if (u == 8'h0a || u == 8'h0d) begin
         r = 6'h3c;
      end else if (u == 8'h7b) begin
         r = 6'h3b;
      end else if (u == 8'h7e) begin
         r = 6'h3d;
      end else if (u == 8'h5c) begin
         r = 6'h20;
      end else if (u < 8'h20 || u > 8'h5d) begin
         r = 6'h20;
      end else begin
         r = d[CODE_W-1:0];
      end
      return r;
   endfunction

   function automatic num_code_type map_numeric(input logic [7:0] c);
      num_code_type r;
      logic [7:0]   d;
      d      = c - 8'h30;
      r.ok   = 1'b1;
      r.code = '0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r.code = d[CODE_W-1:0];
      end else begin
         case (c)
            8'h55:   r.code = 6'd11;   // 'U'
            8'h20:   r.code = 6'd12;   // space
            8'h2d:   r.code = 6'd13;   // '-'
            8'h3d:   r.code = 6'd14;   // '='
            8'h45:   r.code = 6'd15;   // 'E'
            default: r.ok   = 1'b0;
         endcase
      end
      return r;
   endfunction

   // Codeword bit b is returned in bit 14-b: the seven information bits
   // reversed on top, then the eight parity bits.
   function automatic logic [CW_W-1:0] bch_encode(input logic [WORD_W-1:0] info);
      logic [WORD_W-1:0] m;
      logic [CW_W-1:0]   v;
      for (int j = 0; j < WORD_W; j++) begin
         m[WORD_W-1-j] = info[j];
      end
      v = {m, 8'h00};
      for (int i = CW_W-1; i >= 8; i--) begin
         if (v[i]) begin
            v = v ^ (CW_W'(BCH_GEN) << (i - 8));
         end
      end
      return {m, v[7:0]};
   endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/gsc_mbe_assembler.sv -----
// Input register, code buffer and block packing with BCH encoding.
`default_nettype none

module gsc_mbe_assembler (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         message_type,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire gsc_mbe_pkg::req_payload_type req_payload,
   output logic                              blk_valid,
   input  wire logic                         blk_stall,
   output gsc_mbe_pkg::blk_type              blk_data
);

   logic                                 in_valid_ff, in_valid_in;
   gsc_mbe_pkg::req_payload_type         in_data_ff;
   logic [gsc_mbe_pkg::COUNT_W-1:0]      code_count_ff, code_count_in;
   logic [gsc_mbe_pkg::BLOCK_CODES-1:0][gsc_mbe_pkg::CODE_W-1:0] code_buf_ff;

   gsc_mbe_pkg::num_code_type            num;
   logic [gsc_mbe_pkg::CODE_W-1:0]       alpha_code, code, fill;
   logic                                 bad, finish, produces, advance, req_accept;
   logic [gsc_mbe_pkg::BLOCK_CODES-1:0][gsc_mbe_pkg::CODE_W-1:0] c;
   logic [gsc_mbe_pkg::BLOCK_CODES-1:0][gsc_mbe_pkg::WORD_W-1:0] w;

   always_comb begin
      num        = gsc_mbe_pkg::map_numeric(in_data_ff.character);
      alpha_code = gsc_mbe_pkg::map_alpha(in_data_ff.character);
      bad        = (message_type == gsc_mbe_pkg::MSG_NUMERIC) && !num.ok;
      code       = (message_type == gsc_mbe_pkg::MSG_NUMERIC) ? num.code : alpha_code;
      fill       = (message_type == gsc_mbe_pkg::MSG_NUMERIC) ?
                   gsc_mbe_pkg::NUMERIC_FILL : gsc_mbe_pkg::ALPHA_FILL;
      finish     = !bad && ((code_count_ff == gsc_mbe_pkg::LAST_SLOT) ||
                            in_data_ff.last_char);
      produces   = bad || finish;
      advance    = in_valid_ff && (!produces || !blk_stall);
      req_stall  = in_valid_ff && !advance;
      req_accept = req_valid && !req_stall;
      blk_valid  = in_valid_ff && produces;
   end

   // Slots below the count come from the buffer, the current slot takes the
   // new code, and the slots above it are padded with the fill code.
   always_comb begin
      for (int k = 0; k < gsc_mbe_pkg::BLOCK_CODES; k++) begin
         if (gsc_mbe_pkg::COUNT_W'(k) < code_count_ff) begin
            c[k] = code_buf_ff[k];
         end else if (gsc_mbe_pkg::COUNT_W'(k) == code_count_ff) begin
            c[k] = code;
         end else begin
            c[k] = fill;
         end
      end
      w[0] = {c[1][0],   c[0]};
      w[1] = {c[2][1:0], c[1][5:1]};
      w[2] = {c[3][2:0], c[2][5:2]};
      w[3] = {c[4][3:0], c[3][5:3]};
      w[4] = {c[5][4:0], c[4][5:4]};
      w[5] = {c[6],      c[5][5]};
      w[6] = {!in_data_ff.last_char, c[7]};
      w[7] = w[0] + w[1] + w[2] + w[3] + w[4] + w[5] + w[6];
      blk_data.bad = bad;
      for (int k = 0; k < gsc_mbe_pkg::BLOCK_CODES; k++) begin
         blk_data.cw[k] = gsc_mbe_pkg::bch_encode(w[k]);
      end
   end

   always_comb begin
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
      code_count_in = code_count_ff;
      if (advance) begin
         if (produces) begin
            code_count_in = '0;
         end else begin
            code_count_in = code_count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         code_count_ff <= '0;
      end else begin
         in_valid_ff   <= in_valid_in;
         code_count_ff <= code_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_data_ff <= req_payload;
      end
      if (advance && !bad) begin
         code_buf_ff[code_count_ff] <= code;
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/gsc_mbe_serializer.sv -----
// Block holding register and result serialiser: comma bit then fifteen columns.
`default_nettype none

module gsc_mbe_serializer (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          blk_valid,
   output logic                               blk_stall,
   input  wire gsc_mbe_pkg::blk_type          blk_data,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output gsc_mbe_pkg::rsp_payload_type       rsp_payload
);

   logic                                busy_ff, busy_in;
   logic [gsc_mbe_pkg::RES_IDX_W-1:0]   idx_ff, idx_in;
   gsc_mbe_pkg::blk_type                hold_ff;
   logic                                rsp_valid_ff, rsp_valid_in;
   gsc_mbe_pkg::rsp_payload_type        rsp_data_ff, cur;

   logic                                rsp_free, emit, last_res, blk_accept;
   logic [gsc_mbe_pkg::RES_IDX_W-1:0]   sel;

   always_comb begin
      rsp_free   = !rsp_valid_ff || !rsp_stall;
      emit       = busy_ff && rsp_free;
      last_res   = hold_ff.bad || (idx_ff == gsc_mbe_pkg::LAST_IDX);
      blk_stall  = busy_ff && !(emit && last_res);
      blk_accept = blk_valid && !blk_stall;
   end

   // Column b is sent at result b+1 and takes codeword bit b, held at 14-b.
   always_comb begin
      sel = gsc_mbe_pkg::LAST_IDX - idx_ff;
      cur = '0;
      if (hold_ff.bad) begin
         cur.end_of_block = 1'b1;
         cur.bad_char     = 1'b1;
      end else if (idx_ff == gsc_mbe_pkg::COMMA_IDX) begin
         cur.symbol_bits = {!hold_ff.cw[0][gsc_mbe_pkg::CW_W-1], 7'b0};
         cur.bit_count   = gsc_mbe_pkg::COMMA_BITS;
      end else begin
         for (int k = 0; k < gsc_mbe_pkg::BLOCK_CODES; k++) begin
            cur.symbol_bits[7-k] = hold_ff.cw[k][sel];
         end
         cur.bit_count    = gsc_mbe_pkg::COLUMN_BITS;
         cur.end_of_block = (idx_ff == gsc_mbe_pkg::LAST_IDX);
      end
   end

   always_comb begin
      if (blk_accept) begin
         busy_in = 1'b1;
      end else if (emit && last_res) begin
         busy_in = 1'b0;
      end else begin
         busy_in = busy_ff;
      end
      if (blk_accept) begin
         idx_in = '0;
      end else if (emit) begin
         idx_in = idx_ff + 1'b1;
      end else begin
         idx_in = idx_ff;
      end
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (blk_accept) begin
         hold_ff <= blk_data;
      end
      if (emit) begin
         rsp_data_ff <= cur;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/gsc_message_block_encoder_top.sv -----
// Top level of the pager message block encoder with its configuration register.
//
// Message characters enter on the req_ channel, one per transaction, with
// last_char marking the end of a message. Characters are collected eight to
// a block; a block finishes on its eighth character or early on last_char,
// and then yields sixteen rsp_ transactions: one comma bit and fifteen
// interleaved 8-bit columns, the last one flagged end_of_block. An invalid
// numeric character yields a single transaction with bad_char set and
// discards the partial block. The csr_ port holds message_type.
// A character is taken in every cycle unless req_stall holds it; the last
// character of a finished block passes the input register, the block holding
// register and the result register before its first result appears, and
// one result leaves per cycle while rsp_stall is low. A single block holding
// register lets the next block be collected while the current one is sent out.
// Reset clears the code count, empties all stages and sets message_type to
// alphanumeric. When the receiver stalls, the result register holds its
// transaction, the holding register fills and req_stall is raised once a
// finishing character cannot be passed on.
`default_nettype none

module gsc_message_block_encoder_top (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output logic                                        req_stall,
   input  wire gsc_mbe_pkg::req_payload_type           req_payload,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_stall,
   output gsc_mbe_pkg::rsp_payload_type                rsp_payload,
   input  wire logic                                   csr_psel,
   input  wire logic                                   csr_penable,
   input  wire logic                                   csr_pwrite,
   input  wire logic [gsc_mbe_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  wire logic [31:0]                            csr_pwdata,
   output logic [31:0]                                 csr_prdata,
   output logic                                        csr_pready
);

   logic                                  message_type_ff, message_type_in;
   logic [gsc_mbe_pkg::CSR_IDX_W-1:0]     csr_idx;
   logic                                  csr_write;
   logic                                  blk_valid, blk_stall;
   gsc_mbe_pkg::blk_type                  blk_data;

   always_comb begin
      csr_idx         = csr_paddr[gsc_mbe_pkg::CSR_ADDR_W-1:2];
      csr_write       = csr_psel && csr_penable && csr_pwrite && csr_pready;
      message_type_in = message_type_ff;
      if (csr_write && (csr_idx == gsc_mbe_pkg::CSR_MESSAGE_TYPE)) begin
         message_type_in = csr_pwdata[0];
      end
      if (csr_idx == gsc_mbe_pkg::CSR_MESSAGE_TYPE) begin
         csr_prdata = {31'b0, message_type_ff};
      end else begin
         csr_prdata = '0;
      end
   end

   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         message_type_ff <= gsc_mbe_pkg::MSG_ALPHA;
      end else begin
         message_type_ff <= message_type_in;
      end
   end

   gsc_mbe_assembler u_assembler (
      .clock        (clock),
      .reset        (reset),
      .message_type (message_type_ff),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_payload  (req_payload),
      .blk_valid    (blk_valid),
      .blk_stall    (blk_stall),
      .blk_data     (blk_data)
   );

   gsc_mbe_serializer u_serializer (
      .clock       (clock),
      .reset       (reset),
      .blk_valid   (blk_valid),
      .blk_stall   (blk_stall),
      .blk_data    (blk_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

// ----- sim/gsc_message_block_encoder_top_tb.sv -----
// Testbench of the pager message block encoder: directed and random characters against a predictor.
`default_nettype none

module gsc_message_block_encoder_top_tb;

   localparam int unsigned LONG_HOLD      = 300;
   localparam int unsigned SETTLE_CYCLES  = 10;
   localparam int unsigned PHASE_ITEMS    = 48;
   localparam int unsigned RANDOM_PHASES  = 7;
   localparam int unsigned TIMEOUT_UNITS  = 2_000_000;
   localparam logic [gsc_mbe_pkg::CSR_ADDR_W-1:0] ADDR_MESSAGE_TYPE =
      gsc_mbe_pkg::CSR_ADDR_W'(4 * gsc_mbe_pkg::CSR_MESSAGE_TYPE);
   localparam logic [gsc_mbe_pkg::CSR_ADDR_W-1:0] ADDR_BEYOND_LIST  =
      gsc_mbe_pkg::CSR_ADDR_W'(4);

   // Predicts the comma, column and bad_char results of the characters and checks them in order.
   class column_scoreboard;
      logic                                msg_type;
      logic [gsc_mbe_pkg::CODE_W-1:0]      codes [gsc_mbe_pkg::BLOCK_CODES];
      int unsigned                         held;
      gsc_mbe_pkg::rsp_payload_type        expected_columns [$];
      int unsigned                         mismatches;
      int unsigned                         characters;
      int unsigned                         blocks;
      int unsigned                         rejects;

      function new();
         msg_type   = gsc_mbe_pkg::MSG_ALPHA;
         held       = 0;
         mismatches = 0;
         characters = 0;
         blocks     = 0;
         rejects    = 0;
      endfunction

      task report_mismatch(input string what);
         mismatches++;
         $display("[%0t] mismatch: %s", $time, what);
      endtask

      function int unsigned pending();
         return expected_columns.size();
      endfunction

      function void queue_result(input gsc_mbe_pkg::rsp_payload_type r);
         expected_columns.insert(expected_columns.size(), r);
      endfunction

      function logic [gsc_mbe_pkg::CODE_W-1:0] alpha_code(input logic [7:0] ch);
         logic [7:0] u;
         u = (ch >= "a" && ch <= "z") ? ch - 8'h20 : ch;
         case (u)
            8'h0a, 8'h0d: return 6'h3c;
            "{":          return 6'h3b;
            "~":          return 6'h3d;
            "\\":         return 6'h20;
            default: begin
               if (u < 8'h20 || u > 8'h5d) begin
                  return 6'h20;
               end
               return gsc_mbe_pkg::CODE_W'(u - 8'h20);
            end
         endcase
      endfunction

      function gsc_mbe_pkg::num_code_type numeric_code(input logic [7:0] ch);
         gsc_mbe_pkg::num_code_type r;
         r.ok = 1'b1;
         if (ch >= "0" && ch <= "9") begin
            r.code = gsc_mbe_pkg::CODE_W'(ch - "0");
         end else begin
            case (ch)
               "U":     r.code = 6'd11;
               " ":     r.code = 6'd12;
               "-":     r.code = 6'd13;
               "=":     r.code = 6'd14;
               "E":     r.code = 6'd15;
               default: begin
                  r.ok   = 1'b0;
                  r.code = '0;
               end
            endcase
         end
         return r;
      endfunction

      // Serial division by the generator; the result is indexed in transmit order,
      // information bits first, then parity from the highest degree down.
      function logic [gsc_mbe_pkg::CW_W-1:0] encode_word(
         input logic [gsc_mbe_pkg::WORD_W-1:0] w);
         logic [7:0]                    p;
         logic                          fb;
         logic [gsc_mbe_pkg::CW_W-1:0]  cw;
         p = '0;
         for (int j = 0; j < gsc_mbe_pkg::WORD_W; j++) begin
            fb = w[j] ^ p[7];
            p  = {p[6:0], 1'b0} ^ (fb ? gsc_mbe_pkg::BCH_GEN[7:0] : 8'h00);
         end
         cw[gsc_mbe_pkg::WORD_W-1:0] = w;
         for (int j = 0; j < 8; j++) begin
            cw[gsc_mbe_pkg::WORD_W+j] = p[7-j];
         end
         return cw;
      endfunction

      function void note_character(input gsc_mbe_pkg::req_payload_type item);
         gsc_mbe_pkg::num_code_type        num;
         logic [gsc_mbe_pkg::CODE_W-1:0]   code;
         logic [41:0]                      stream;
         logic [gsc_mbe_pkg::WORD_W-1:0]   words [8];
         logic [gsc_mbe_pkg::WORD_W-1:0]   sum;
         logic [gsc_mbe_pkg::CW_W-1:0]     cw [8];
         gsc_mbe_pkg::rsp_payload_type     r;
         characters++;
         if (msg_type == gsc_mbe_pkg::MSG_NUMERIC) begin
            num = numeric_code(item.character);
         end else begin
            num.ok   = 1'b1;
            num.code = alpha_code(item.character);
         end
         if (!num.ok) begin
            held = 0;
            rejects++;
            r = '0;
            r.end_of_block = 1'b1;
            r.bad_char     = 1'b1;
            queue_result(r);
            return;
         end
         code        = num.code;
         codes[held] = code;
         held++;
         if (held < gsc_mbe_pkg::BLOCK_CODES && !item.last_char) begin
            return;
         end
         for (int k = held; k < gsc_mbe_pkg::BLOCK_CODES; k++) begin
            codes[k] = (msg_type == gsc_mbe_pkg::MSG_NUMERIC) ?
                       gsc_mbe_pkg::NUMERIC_FILL : gsc_mbe_pkg::ALPHA_FILL;
         end
         held = 0;
         blocks++;
         // The first seven codes form one bit stream that is cut into six words.
         stream = {codes[6], codes[5], codes[4], codes[3], codes[2], codes[1], codes[0]};
         sum    = '0;
         for (int k = 0; k < 6; k++) begin
            words[k] = stream[7*k +: 7];
         end
         words[6] = {~item.last_char, codes[7]};
         for (int k = 0; k < 7; k++) begin
            sum = sum + words[k];
         end
         words[7] = sum;
         for (int k = 0; k < 8; k++) begin
            cw[k] = encode_word(words[k]);
         end
         r = '0;
         r.symbol_bits = {~cw[0][0], 7'b0};
         r.bit_count   = gsc_mbe_pkg::COMMA_BITS;
         queue_result(r);
         for (int b = 0; b < gsc_mbe_pkg::CW_W; b++) begin
            r = '0;
            for (int k = 0; k < 8; k++) begin
               r.symbol_bits[7-k] = cw[k][b];
            end
            r.bit_count    = gsc_mbe_pkg::COLUMN_BITS;
            r.end_of_block = (b == gsc_mbe_pkg::CW_W - 1);
            queue_result(r);
         end
      endfunction

      task check_result(input gsc_mbe_pkg::rsp_payload_type got);
         gsc_mbe_pkg::rsp_payload_type want;
         if (expected_columns.size() == 0) begin
            report_mismatch($sformatf("result %h with nothing expected", got));
            return;
         end
         want = expected_columns.pop_front();
         if (got.symbol_bits !== want.symbol_bits) begin
            report_mismatch($sformatf("symbol_bits %h, expected %h",
                                      got.symbol_bits, want.symbol_bits));
         end
         if (got.bit_count !== want.bit_count) begin
            report_mismatch($sformatf("bit_count %0d, expected %0d",
                                      got.bit_count, want.bit_count));
         end
         if (got.end_of_block !== want.end_of_block) begin
            report_mismatch($sformatf("end_of_block %b, expected %b",
                                      got.end_of_block, want.end_of_block));
         end
         if (got.bad_char !== want.bad_char) begin
            report_mismatch($sformatf("bad_char %b, expected %b",
                                      got.bad_char, want.bad_char));
         end
      endtask
   endclass

   logic                                  clock       = 1'b0;
   logic                                  reset       = 1'b1;
   logic                                  req_valid   = 1'b0;
   logic                                  req_stall;
   gsc_mbe_pkg::req_payload_type          req_payload = '0;
   logic                                  rsp_valid;
   logic                                  rsp_stall   = 1'b1;
   gsc_mbe_pkg::rsp_payload_type          rsp_payload;
   logic                                  csr_psel    = 1'b0;
   logic                                  csr_penable = 1'b0;
   logic                                  csr_pwrite  = 1'b0;
   logic [gsc_mbe_pkg::CSR_ADDR_W-1:0]    csr_paddr   = '0;
   logic [31:0]                           csr_pwdata  = '0;
   logic [31:0]                           csr_prdata;
   logic                                  csr_pready;

   bit          calm        = 1'b0;
   bit          sender_gaps = 1'b1;
   bit          long_hold   = 1'b0;
   int unsigned csr_writes  = 0;

   column_scoreboard column_board = new();

   gsc_message_block_encoder_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      #(TIMEOUT_UNITS);
      $display("Simulation FAILED");
      $finish;
   end

   // Both handshakes are sampled at the edge, so values seen are those before it.
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         column_board.note_character(req_payload);
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         column_board.check_result(rsp_payload);
      end
   end

   // Receiver: random stall bursts, one long hold-off on request, none when calm.
   initial begin : receiver
      forever begin
         if (long_hold) begin
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
            long_hold = 1'b0;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 9)) @(posedge clock);
         end else begin
            rsp_stall <= 1'b0;
            repeat (calm ? 1 : $urandom_range(1, 12)) @(posedge clock);
         end
      end
   end

   task send_char(input logic [7:0] ch, input logic last);
      if (sender_gaps && !calm && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= '{character: ch, last_char: last};
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task wait_for_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (column_board.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task csr_write(input logic [gsc_mbe_pkg::CSR_ADDR_W-1:0] addr, input logic [31:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (addr == ADDR_MESSAGE_TYPE) begin
         column_board.msg_type = data[0];
      end
      csr_writes++;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task csr_check_type();
      logic [31:0] value;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= ADDR_MESSAGE_TYPE;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      value = csr_prdata;
      if (value !== {31'b0, column_board.msg_type}) begin
         column_board.report_mismatch($sformatf("message_type reads %h, expected %0d",
                                                value, column_board.msg_type));
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // The upper data bits are random so that only bit 0 is seen to matter.
   task set_message_type(input logic kind);
      logic [31:0] data;
      data    = $urandom();
      data[0] = kind;
      csr_write(ADDR_MESSAGE_TYPE, data);
      csr_check_type();
   endtask

   function automatic logic [7:0] pick_character(input logic numeric);
      string numeric_set = "0123456789U -=E";
      if (numeric) begin
         // Mostly well-formed digits, with the odd invalid byte to break a block.
         if ($urandom_range(0, 11) != 0) begin
            return numeric_set[$urandom_range(0, numeric_set.len() - 1)];
         end
         return 8'($urandom_range(0, 255));
      end
      if ($urandom_range(0, 3) == 0) begin
         return 8'($urandom_range(0, 255));
      end
      return 8'($urandom_range(8'h20, 8'h7e));
   endfunction

   task run_phase(input logic numeric, input int unsigned count);
      for (int i = 0; i < count; i++) begin
         send_char(pick_character(numeric), $urandom_range(0, 6) == 0);
      end
      wait_for_drain();
   endtask

   initial begin : stimulus
      logic kind;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Alphanumeric extremes: a full block, then an early one closed by last_char.
      set_message_type(gsc_mbe_pkg::MSG_ALPHA);
      send_char(8'h00, 1'b0);
      send_char(8'hff, 1'b0);
      send_char("a", 1'b0);
      send_char("z", 1'b0);
      send_char("{", 1'b0);
      send_char("~", 1'b0);
      send_char("\\", 1'b0);
      send_char(8'h0a, 1'b0);
      send_char(8'h0d, 1'b0);
      send_char(8'h5d, 1'b0);
      send_char(8'h5e, 1'b0);
      send_char(8'h1f, 1'b0);
      send_char(" ", 1'b0);
      send_char("A", 1'b1);
      wait_for_drain();

      // Numeric codes, an invalid character mid-block and one carrying last_char.
      set_message_type(gsc_mbe_pkg::MSG_NUMERIC);
      send_char("0", 1'b0);
      send_char("9", 1'b0);
      send_char("U", 1'b0);
      send_char(" ", 1'b0);
      send_char("-", 1'b0);
      send_char("=", 1'b0);
      send_char("E", 1'b0);
      send_char("5", 1'b0);
      send_char("3", 1'b0);
      send_char("Q", 1'b0);
      send_char("7", 1'b0);
      send_char(8'hff, 1'b1);
      wait_for_drain();

      // A write past the register list must leave message_type alone.
      csr_write(ADDR_BEYOND_LIST, 32'hffff_fffe);
      csr_check_type();

      // The receiver holds off while blocks keep arriving.
      set_message_type(gsc_mbe_pkg::MSG_ALPHA);
      sender_gaps = 1'b0;
      long_hold   = 1'b1;
      run_phase(gsc_mbe_pkg::MSG_ALPHA, PHASE_ITEMS);
      sender_gaps = 1'b1;

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         kind = (p < 2) ? logic'(p) : logic'($urandom_range(0, 1));
         if (p == RANDOM_PHASES - 1) begin
            calm = 1'b1;
         end
         set_message_type(kind);
         run_phase(kind, PHASE_ITEMS);
      end

      if (column_board.pending() != 0) begin
         column_board.report_mismatch($sformatf("%0d results never arrived",
                                                column_board.pending()));
      end
      $display("Covered %0d characters, %0d finished blocks and %0d rejected characters",
               column_board.characters, column_board.blocks, column_board.rejects);
      $display("over %0d register writes, with one %0d-cycle receiver hold-off.",
               csr_writes, LONG_HOLD);
      if (column_board.mismatches == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire
